### rtl/core/hcbd_pkg.sv
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types and constants for the chunked body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

    // longest size line in bytes, digits plus CR LF
    localparam int SIZE_LINE_MAX = 6;
    localparam int LP_W          = $clog2(SIZE_LINE_MAX);

    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

    // one classified input word
    typedef struct packed {
        logic       closed;
        logic [7:0] data;
        logic       is_hex;
        logic [3:0] hex_val;
        logic       is_cr;
        logic       is_lf;
    } t_item;

    typedef struct packed {
        logic        limit_enable;
        logic [31:0] body_limit;
    } t_cfg;

endpackage

### rtl/core/hcbd_front.sv
// ----------------------------------------------------------------------------
// hcbd_front
// Input side: takes words while the queue has room and classifies each byte.
// ----------------------------------------------------------------------------
module hcbd_front (
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_data_byte,
    input  logic          i_stream_end,
    input  logic          i_full,
    output logic          o_push,
    output hcbd_pkg::t_item o_item
);
    import hcbd_pkg::*;

    logic [7:0] w_b;

    assign w_b     = i_data_byte;
    assign o_ready = ~i_full;
    assign o_push  = i_valid & ~i_full;

    always_comb begin
        o_item.closed  = i_stream_end;
        o_item.data    = w_b;
        o_item.is_cr   = (w_b == 8'h0D);
        o_item.is_lf   = (w_b == 8'h0A);
        o_item.is_hex  = 1'b0;
        o_item.hex_val = 4'd0;
        if (w_b >= 8'h30 && w_b <= 8'h39) begin
            o_item.is_hex  = 1'b1;
            o_item.hex_val = 4'(w_b - 8'h30);
        end else if (w_b >= 8'h41 && w_b <= 8'h46) begin
            o_item.is_hex  = 1'b1;
            o_item.hex_val = 4'(w_b - 8'h41 + 8'd10);
        end else if (w_b >= 8'h61 && w_b <= 8'h66) begin
            o_item.is_hex  = 1'b1;
            o_item.hex_val = 4'(w_b - 8'h61 + 8'd10);
        end
    end

endmodule

### rtl/core/hcbd_queue.sv
// ----------------------------------------------------------------------------
// hcbd_queue
// Short FIFO of classified words between the front and back ends.
// ----------------------------------------------------------------------------
module hcbd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hcbd_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_nonempty,
    output hcbd_pkg::t_item o_item
);
    import hcbd_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QPTR_W:0]   r_count, n_count;
    logic              w_pop;

    assign o_full     = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_item     = r_mem[r_rd_ptr];
    assign w_pop      = i_pop & o_nonempty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, w_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

### rtl/core/hcbd_back.sv
// ----------------------------------------------------------------------------
// hcbd_back
// Parser state machine: size line, payload, skip bytes, budget, end states.
// Holds the result in an output register.
// ----------------------------------------------------------------------------
module hcbd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hcbd_pkg::t_cfg  i_cfg,
    input  logic            i_nonempty,
    input  hcbd_pkg::t_item i_item,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_out_valid,
    output logic [2:0]      o_status
);
    import hcbd_pkg::*;

    localparam logic [2:0] PH_SIZE     = 3'd0;
    localparam logic [2:0] PH_LF       = 3'd1;
    localparam logic [2:0] PH_BODY     = 3'd2;
    localparam logic [2:0] PH_COMPLETE = 3'd3;
    localparam logic [2:0] PH_BUDGET   = 3'd4;
    localparam logic [2:0] PH_ENC_ERR  = 3'd5;
    localparam logic [2:0] PH_OVER     = 3'd6;
    localparam logic [2:0] PH_LOST     = 3'd7;

    localparam logic [LP_W-1:0] LP_DIGIT_MAX = LP_W'(SIZE_LINE_MAX - 3);

    logic [2:0]      r_phase, n_phase;
    logic [LP_W-1:0] r_line_pos, n_line_pos;
    logic [15:0]     r_chunk_len, n_chunk_len;
    logic [16:0]     r_remaining, n_remaining;
    logic [31:0]     r_body_count, n_body_count;
    logic            r_final, n_final;
    logic            r_valid;
    logic [7:0]      r_out_byte, n_out_byte;
    logic            r_out_valid, n_out_valid;

    logic [31:0] w_left;
    logic [16:0] w_rem_dec;

    assign o_pop       = i_nonempty & (~r_valid | i_ready);
    assign o_valid     = r_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_valid = r_out_valid;
    assign o_status    = (r_phase > PH_BODY) ? 3'(r_phase - PH_BODY) : 3'd0;

    assign w_left    = (i_cfg.body_limit > r_body_count) ?
                       (i_cfg.body_limit - r_body_count) : 32'd0;
    assign w_rem_dec = r_remaining - 17'd1;

    always_comb begin
        n_phase      = r_phase;
        n_line_pos   = r_line_pos;
        n_chunk_len  = r_chunk_len;
        n_remaining  = r_remaining;
        n_body_count = r_body_count;
        n_final      = r_final;
        n_out_byte   = 8'd0;
        n_out_valid  = 1'b0;
        case (r_phase)
            PH_SIZE: begin
                if (r_line_pos == '0 && i_cfg.limit_enable &&
                    r_body_count >= i_cfg.body_limit) begin
                    n_phase = PH_BUDGET;
                end else if (i_item.closed) begin
                    n_phase = PH_ENC_ERR;
                end else if (i_item.is_cr) begin
                    if (r_line_pos == '0) begin
                        n_phase = PH_ENC_ERR;
                    end else begin
                        n_phase    = PH_LF;
                        n_line_pos = r_line_pos + 1'b1;
                    end
                end else if (!i_item.is_hex || r_line_pos > LP_DIGIT_MAX) begin
                    n_phase = PH_ENC_ERR;
                end else if (r_chunk_len[15:12] != 4'd0) begin
                    n_phase = PH_ENC_ERR;
                end else begin
                    n_chunk_len = {r_chunk_len[11:0], i_item.hex_val};
                    n_line_pos  = r_line_pos + 1'b1;
                end
            end
            PH_LF: begin
                if (i_item.closed || !i_item.is_lf) begin
                    n_phase = PH_ENC_ERR;
                end else if (i_cfg.limit_enable && ({16'd0, r_chunk_len} > w_left)) begin
                    n_phase = PH_OVER;
                end else begin
                    n_final     = (r_chunk_len == 16'd0);
                    n_remaining = {1'b0, r_chunk_len} + 17'd2;
                    n_phase     = PH_BODY;
                end
            end
            PH_BODY: begin
                if (i_item.closed) begin
                    n_phase = PH_LOST;
                end else begin
                    if (r_remaining > 17'd2) begin
                        n_out_byte  = i_item.data;
                        n_out_valid = 1'b1;
                        if (r_body_count != 32'hFFFF_FFFF) begin
                            n_body_count = r_body_count + 32'd1;
                        end
                    end
                    // remaining is at least two on entry, never zero here
                    n_remaining = w_rem_dec;
                    if (w_rem_dec == 17'd0) begin
                        if (r_final) begin
                            n_phase = PH_COMPLETE;
                        end else begin
                            n_phase     = PH_SIZE;
                            n_line_pos  = '0;
                            n_chunk_len = 16'd0;
                        end
                    end
                end
            end
            default: begin
                // end states are sticky
                n_phase = r_phase;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SIZE;
            r_line_pos   <= '0;
            r_chunk_len  <= 16'd0;
            r_remaining  <= 17'd0;
            r_body_count <= 32'd0;
            r_final      <= 1'b0;
            r_valid      <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase      <= n_phase;
                r_line_pos   <= n_line_pos;
                r_chunk_len  <= n_chunk_len;
                r_remaining  <= n_remaining;
                r_body_count <= n_body_count;
                r_final      <= n_final;
                r_valid      <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_byte  <= n_out_byte;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### rtl/core/http_chunked_body_decoder_top.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_top
// Chunked transfer body decoder with optional payload byte budget.
//
//   channel  direction  handshake          payload
//   input    in         i_valid / o_ready  i_data_byte, i_stream_end
//   result   out        o_valid / i_ready  o_out_byte, o_out_valid, o_status
//   config   in         APB psel/penable   paddr, pwdata, prdata
//
// One word in, one result out; sustained rate is one word per cycle while
// the output is not stalled. Words are classified into the queue, then the
// parser state machine loads the output register. Reset is synchronous,
// active low, and clears parser state and the queue. A stalled output holds
// the result while the two-entry queue keeps taking words until it fills.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_stream_end,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_out_valid,
    output logic [2:0]  o_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import hcbd_pkg::*;

    localparam logic REG_LIMIT_ENABLE = 1'b0;
    localparam logic REG_BODY_LIMIT   = 1'b1;

    t_cfg  r_cfg;
    t_item w_front_item;
    t_item w_queue_item;
    logic  w_push;
    logic  w_full;
    logic  w_nonempty;
    logic  w_pop;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BODY_LIMIT) ? r_cfg.body_limit :
                    {31'd0, r_cfg.limit_enable};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_LIMIT_ENABLE: r_cfg.limit_enable <= pwdata[0];
                REG_BODY_LIMIT:   r_cfg.body_limit   <= pwdata;
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    hcbd_front u_front (
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .i_stream_end (i_stream_end),
        .i_full       (w_full),
        .o_push       (w_push),
        .o_item       (w_front_item)
    );

    hcbd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_item     (w_front_item),
        .o_full     (w_full),
        .i_pop      (w_pop),
        .o_nonempty (w_nonempty),
        .o_item     (w_queue_item)
    );

    hcbd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_nonempty  (w_nonempty),
        .i_item      (w_queue_item),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_out_valid (o_out_valid),
        .o_status    (o_status)
    );

endmodule
